// File: hdl/neighbor_range_spike_filter_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the neighbor range spike filter
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_RANGE_SPIKE_FILTER_TOP_ASSERT_SVH
`define NEIGHBOR_RANGE_SPIKE_FILTER_TOP_ASSERT_SVH

// same-cycle implication, idle during reset
`define NRSF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nrsf check failed");

// next-cycle implication, idle during reset
`define NRSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nrsf check failed");

// same-cycle implication, also checked while reset is high
`define NRSF_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("nrsf check failed");

`endif

// File: hdl/nrsf_pkg.sv
// ---------------------------------------------------------------------------
// nrsf_pkg
// Fixed constants of the neighbor range spike filter.
// ---------------------------------------------------------------------------
package nrsf_pkg;

  // strength register: unsigned Q4.12
  localparam int STRENGTH_WIDTH = 16;
  localparam logic [STRENGTH_WIDTH-1:0] STRENGTH_RESET = 16'd4096;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

endpackage

// File: hdl/neighbor_range_spike_filter_top.sv
// ---------------------------------------------------------------------------
// neighbor_range_spike_filter_top
// Streaming spike filter: replaces a sample that leaves its neighbor range.
// ---------------------------------------------------------------------------
// Usage:
//   s_* : input words. s_tdata[SAMPLE_WIDTH-1:0] = signed sample,
//         s_tlast marks the final sample of a run.
//   m_* : result words. m_tdata[SAMPLE_WIDTH-1:0] = filtered sample,
//         m_tlast marks the final result of a run.
//   cfg_* : writes the Q4.12 strength (cfg_data); always ready.
//         Write only while the block is idle.
// Each interior sample is checked against the filtered sample before it
// and the raw sample after it, so a result trails its input by one word;
// the word carrying s_tlast releases two results (the held sample and
// itself). A single-word run passes straight through.
// Path: input register -> combinational filter logic -> 4-entry result
// queue. A completing word is registered, then its result is written to
// the queue and shown on m_*. One word per cycle is sustained; a run end
// pushes two results, so the input pauses when the queue has fewer than
// two free slots (downstream stall backs up into s_tready).
// Reset (rst, synchronous): queue and input register empty, filter state
// cleared, strength = 1.0 (4096).
// ---------------------------------------------------------------------------
module neighbor_range_spike_filter_top #(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int STRENGTH_FRAC_BITS = 12,
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [DW-1:0]                       s_tdata,   // [SW-1:0] sample_in
  input  logic                                s_tlast,   // end_of_run
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [DW-1:0]                       m_tdata,   // [SW-1:0] sample_out
  output logic                                m_tlast,   // last_out
  // strength register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nrsf_pkg::STRENGTH_WIDTH-1:0] cfg_data   // strength, Q4.12
);
  import nrsf_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + STRENGTH_WIDTH + 2;  // product width
  localparam int CW = PW + 1;                   // compare width

  // phase of the run
  localparam logic [1:0] PH_IDLE  = 2'd0;  // awaiting first sample
  localparam logic [1:0] PH_FIRST = 2'd1;  // holding the first sample
  localparam logic [1:0] PH_MID   = 2'd2;  // holding an interior sample

  // config
  logic [STRENGTH_WIDTH-1:0] strength;

  // input register
  logic                 in_valid;
  logic signed [SW-1:0] in_sample;
  logic                 in_last;

  // filter state
  logic signed [SW-1:0] prev_filtered, prev_filtered_next;
  logic signed [SW-1:0] held_sample;
  logic [1:0]           phase, phase_next;

  // result queue
  logic [SW-1:0]      fifo_sample [FIFO_DEPTH];
  logic               fifo_last   [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head, tail;
  logic [FIFO_CW-1:0] count;

  logic               fire, pop;
  logic [1:0]         push_n;
  logic [SW-1:0]      res0_sample, res1_sample;
  logic               res0_last;

  // filter datapath
  logic signed [SW:0]   sum_pn, diff;
  logic signed [SW-1:0] mid;
  logic signed [PW-1:0] prod, margin;
  logic signed [CW-1:0] hi_lim, lo_lim, s_ext;
  logic                 replace;
  logic signed [SW-1:0] filtered;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= STRENGTH_RESET;
    end else if (cfg_valid) begin
      strength <= cfg_data;
    end
  end

  // queue must hold two more results before a word is processed
  assign fire     = in_valid && (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= $signed(s_tdata[SW-1:0]);
      in_last   <= s_tlast;
    end
  end

  // p = prev_filtered, s = held_sample, n = in_sample
  always_comb begin
    sum_pn  = {prev_filtered[SW-1], prev_filtered} + {in_sample[SW-1], in_sample};
    mid     = sum_pn[SW:1];  // floor of half
    diff    = {mid[SW-1], mid} - {prev_filtered[SW-1], prev_filtered};
    prod    = PW'(diff) * PW'($signed({1'b0, strength}));
    margin  = prod >>> STRENGTH_FRAC_BITS;  // floor
    hi_lim  = CW'(in_sample) + CW'(margin);
    lo_lim  = CW'(prev_filtered) - CW'(margin);
    s_ext   = CW'(held_sample);
    if (prev_filtered < in_sample) begin
      replace = (s_ext > hi_lim) || (s_ext < lo_lim);
    end else begin
      replace = (s_ext < hi_lim) || (s_ext > lo_lim);
    end
    filtered = replace ? mid : held_sample;
  end

  // run sequencing
  always_comb begin
    phase_next         = phase;
    prev_filtered_next = prev_filtered;
    push_n             = 2'd0;
    res0_sample        = in_sample;
    res0_last          = 1'b1;
    res1_sample        = in_sample;
    unique case (phase)
      PH_IDLE: begin
        if (in_last) begin
          push_n = 2'd1;
        end else begin
          phase_next = PH_FIRST;
        end
      end
      PH_FIRST: begin
        res0_sample        = held_sample;
        res0_last          = 1'b0;
        prev_filtered_next = held_sample;
        push_n             = in_last ? 2'd2 : 2'd1;
        phase_next         = in_last ? PH_IDLE : PH_MID;
      end
      default: begin  // interior, also the unused code
        res0_sample        = filtered;
        res0_last          = 1'b0;
        prev_filtered_next = filtered;
        push_n             = in_last ? 2'd2 : 2'd1;
        phase_next         = in_last ? PH_IDLE : PH_MID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      prev_filtered <= '0;
      held_sample   <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      prev_filtered <= prev_filtered_next;
      held_sample   <= in_sample;
    end
  end

  // result queue
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_tdata  = DW'(fifo_sample[head]);
  assign m_tlast  = fifo_last[head];

  always_ff @(posedge clk) begin
    if (fire && push_n != 2'd0) begin
      fifo_sample[tail] <= res0_sample;
      fifo_last[tail]   <= res0_last;
    end
    if (fire && push_n == 2'd2) begin
      fifo_sample[tail + FIFO_AW'(1)] <= res1_sample;
      fifo_last[tail + FIFO_AW'(1)]   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + FIFO_AW'(1);
      end
      if (fire) begin
        tail <= tail + FIFO_AW'(push_n);
      end
      count <= count + (fire ? FIFO_CW'(push_n) : '0) - FIFO_CW'(pop);
    end
  end

endmodule

// File: hdl/nrsf_checker.sv
// ---------------------------------------------------------------------------
// nrsf_checker
// Port-level checks for the spike filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "neighbor_range_spike_filter_top_assert.svh"

module nrsf_checker #(
  parameter int SAMPLE_WIDTH = 24,
  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [DW-1:0]                       s_tdata,   // [SW-1:0] sample_in
  input logic                                s_tlast,   // end_of_run
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [DW-1:0]                       m_tdata,   // [SW-1:0] sample_out
  input logic                                m_tlast,   // last_out
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [nrsf_pkg::STRENGTH_WIDTH-1:0] cfg_data   // strength
);
  import nrsf_pkg::*;

  logic stalled;
  assign stalled = m_tvalid && !m_tready;

  // a stalled result word holds
  `NRSF_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // nothing comes out right after reset, and input is open
  `NRSF_ASSERT_ALWAYS(a_reset_empty, clk, !rst && $past(rst), !m_tvalid && s_tready)

  // input only backs up when results are waiting
  `NRSF_ASSERT_NOW(a_backpressure, clk, rst, !s_tready, m_tvalid)

  // strength register never stalls
  `NRSF_ASSERT_NOW(a_cfg_open, clk, rst, cfg_valid || !cfg_valid, cfg_ready)

endmodule

bind neighbor_range_spike_filter_top nrsf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_nrsf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .cfg_data (cfg_data)
);

// File: test/neighbor_range_spike_filter_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbor_range_spike_filter_top_tb
// Self-checking bench for the spike filter. Drives runs of signed samples,
// predicts each filtered word from a bit-exact model of the neighbor range
// test, and checks every result word in order, across several strengths.
// ---------------------------------------------------------------------------
module neighbor_range_spike_filter_top_tb;

  localparam int SAMPLE_W       = 24;
  localparam int FRAC_BITS      = 12;
  localparam int DATA_W         = ((SAMPLE_W + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
  localparam int HOLD_OFF_LEN   = 300;   // long result stall
  localparam int SETTLE_CYCLES  = 10;    // settle margin after the queue drains
  localparam int SEGMENT_WORDS  = 225;   // random words per strength
  localparam int NUM_SEGMENTS   = 8;
  localparam int MAX_PRINTED    = 30;

  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

  typedef logic signed [SAMPLE_W-1:0]                 sample_t;
  typedef logic [nrsf_pkg::STRENGTH_WIDTH-1:0]        strength_t;
  typedef enum logic [1:0] {AWAIT_FIRST, HOLD_FIRST, HOLD_INTERIOR} run_phase_t;

  typedef struct {
    sample_t sample;
    logic    last;
  } filtered_word_t;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of the filter state, queue of expected words
  // -------------------------------------------------------------------------
  class spike_filter_scoreboard;
    strength_t      strength;
    sample_t        prev_filtered;
    sample_t        held;
    run_phase_t     phase;
    filtered_word_t expected_q[$];
    int             mismatches;

    function new();
      strength      = nrsf_pkg::STRENGTH_RESET;
      prev_filtered = '0;
      held          = '0;
      phase         = AWAIT_FIRST;
      mismatches    = 0;
    endfunction

    // replace s by the floored midpoint when it leaves the widened range
    function sample_t despike(sample_t p, sample_t s, sample_t n);
      longint pv, sv, nv, mid, margin;
      bit     replace;
      pv     = p;
      sv     = s;
      nv     = n;
      mid    = (pv + nv) >>> 1;
      margin = ((mid - pv) * longint'(strength)) >>> FRAC_BITS;
      if (pv < nv) begin
        replace = (sv > nv + margin) || (sv < pv - margin);
      end else begin
        replace = (sv < nv + margin) || (sv > pv - margin);
      end
      return replace ? sample_t'(mid) : s;
    endfunction

    function void take_sample(sample_t x, logic end_flag);
      sample_t emitted;
      if (phase == AWAIT_FIRST) begin
        // single-word run goes straight through
        if (end_flag) begin
          expected_q.push_back('{x, 1'b1});
        end else begin
          held  = x;
          phase = HOLD_FIRST;
        end
        return;
      end
      emitted = (phase == HOLD_FIRST) ? held : despike(prev_filtered, held, x);
      expected_q.push_back('{emitted, 1'b0});
      prev_filtered = emitted;
      held          = x;
      if (end_flag) begin
        expected_q.push_back('{x, 1'b1});
        phase = AWAIT_FIRST;
      end else begin
        phase = HOLD_INTERIOR;
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(sample_t got, logic got_last);
      filtered_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d last %0b", got, got_last));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want.sample)
        report_mismatch($sformatf("sample %0d, want %0d", got, want.sample));
      if (got_last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b (sample %0d)",
                                  got_last, want.last, want.sample));
    endtask

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Signals, all inputs known from time zero
  // -------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;   // [23:0] sample_in
  logic              s_tlast   = 1'b0; // end_of_run
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;          // [23:0] sample_out
  logic              m_tlast;          // last_out
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  strength_t         cfg_data  = '0;

  spike_filter_scoreboard sb;
  int  idle_cycles = 0;
  int  words_sent  = 0;
  int  burst_left  = 1;
  bit  offer_on    = 1'b0;  // mirrors s_tvalid as last assigned
  bit  hold_off_req = 1'b0; // asks the receiver for one long stall

  neighbor_range_spike_filter_top #(
    .SAMPLE_WIDTH      (SAMPLE_W),
    .STRENGTH_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Monitor: notes accepted inputs before checking results of the same edge.
  // Also the watchdog: any word or register write moving clears it.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.take_sample(sample_t'(s_tdata[SAMPLE_W-1:0]), s_tlast);
      if (m_tvalid && m_tready) sb.check_result(sample_t'(m_tdata[SAMPLE_W-1:0]), m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("neighbor_range_spike_filter_top_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: stretches of random stall patterns, one long hold-off on request
  // -------------------------------------------------------------------------
  initial begin
    int mode;
    int stretch;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        // input keeps offering while results back up into s_tready
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
        repeat (stretch) begin
          case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks
  // -------------------------------------------------------------------------

  // offer one word, wait for the handshake, then maybe open a gap
  task send_word(sample_t x, logic end_flag);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(unsigned'(x));
    s_tlast  <= end_flag;
    offer_on  = 1'b1;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        offer_on  = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every expected word has come back
  task drain();
    if (offer_on) begin
      s_tvalid <= 1'b0;
      offer_on  = 1'b0;
    end
    // let the monitor note the last accepted word first
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the filter idle, between runs
  task write_strength(strength_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.strength = value;
  endtask

  function automatic sample_t clamp_sample(longint v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return sample_t'(SAMPLE_MAX);
      1: return sample_t'(SAMPLE_MIN);
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // one run: mostly slow waveforms with spikes, some noise and extremes
  task send_random_run();
    int     len;
    int     kind;
    longint base;
    longint v;
    int     step_span;
    case ($urandom_range(0, 7))
      0: len = 1;
      1: len = 2;
      2: len = $urandom_range(40, 80);
      default: len = $urandom_range(3, 24);
    endcase
    kind      = $urandom_range(0, 9);
    base      = longint'($urandom_range(0, 8388607)) - 4194304;
    step_span = (kind == 3) ? 0 : $urandom_range(1, 2000);
    for (int i = 0; i < len; i++) begin
      case (kind)
        0, 1: v = longint'(sample_t'($urandom()));
        2:    v = longint'(pick_extreme());
        default: begin
          base = base + longint'($urandom_range(0, 2 * step_span)) - step_span;
          v    = base;
          if ($urandom_range(0, 4) == 0) begin
            // spike up or down, small to huge
            if ($urandom_range(0, 1) != 0) v = base + $urandom_range(1, 4000000);
            else                           v = base - $urandom_range(1, 4000000);
          end
        end
      endcase
      send_word(clamp_sample(v), i == len - 1);
    end
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int        dir_vals[$];
    int        dir_lens[$];
    int        pos;
    int        target;
    strength_t seg_strength[NUM_SEGMENTS];

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed runs at reset strength: single-word runs at both extremes,
    // a two-word run, spikes above and below a rising pair and above a falling
    // one, a flat stretch where both neighbors are equal, full-swing alternation
    dir_vals = '{8388607,
                 -8388608,
                 -8388608, 8388607,
                 0, 5000, 100, 200,
                 100, -5000, 200, 300,
                 1000, 3000, 0, -100,
                 50, 50, 50, 60, 50,
                 8388607, -8388608, 8388607, -8388608};
    dir_lens = '{1, 1, 2, 4, 4, 4, 5, 4};
    pos = 0;
    foreach (dir_lens[r]) begin
      for (int i = 0; i < dir_lens[r]; i++) begin
        send_word(sample_t'(dir_vals[pos]), i == dir_lens[r] - 1);
        pos++;
      end
    end
    drain();

    // random runs, one strength per segment, extremes included
    seg_strength[0] = '0;
    seg_strength[1] = '1;
    seg_strength[2] = 16'd1;
    seg_strength[3] = 16'd2048;
    seg_strength[4] = 16'd8192;
    seg_strength[5] = strength_t'($urandom_range(0, 65535));
    seg_strength[6] = 16'd32768;
    seg_strength[7] = nrsf_pkg::STRENGTH_RESET;
    target = words_sent;
    for (int k = 0; k < NUM_SEGMENTS; k++) begin
      write_strength(seg_strength[k]);
      if (k == 1) hold_off_req = 1'b1;
      target += SEGMENT_WORDS;
      while (words_sent < target) send_random_run();
      drain();
    end

    // anything still queued never arrived
    while (sb.outstanding() != 0) begin
      sb.report_mismatch($sformatf("missing word %0d", sb.expected_q[0].sample));
      void'(sb.expected_q.pop_front());
    end
    if (sb.mismatches == 0) begin
      $display("neighbor_range_spike_filter_top_tb passed");
    end else begin
      $display("neighbor_range_spike_filter_top_tb failed");
    end
    $finish;
  end

endmodule
